### rtl/qswd_pkg.sv
package qswd_pkg;

    localparam int NUM_CELLS = 16;
    localparam int NUM_ROT   = 4;
    localparam int SYM_VALS  = 4;

    typedef enum logic [1:0] {
        REG_SYNC_CODE       = 2'd0,
        REG_COMPARE_MASK    = 2'd1,
        REG_ERROR_THRESHOLD = 2'd2,
        REG_FRAME_LEN       = 2'd3
    } reg_index_t;

    typedef logic [1:0] sym_t;
    typedef logic [1:0] rot_t;
    typedef logic [1:0] err_t;
    typedef err_t [NUM_ROT-1:0] err_set_t;

    typedef struct packed {
        logic found;
        rot_t phase;
    } match_t;

    localparam logic [63:0] START_BACK = 64'd15;
    localparam logic [18:0] TAG_EXTRA  = 19'd16;

    localparam sym_t ROT_MAP [NUM_ROT][SYM_VALS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd3, 2'd0, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd2, 2'd0, 2'd3, 2'd1}
    };

    function automatic sym_t rot_sym(input rot_t rot, input sym_t s);
        return ROT_MAP[rot][s];
    endfunction

    function automatic err_t count_bits(input sym_t d);
        return {1'b0, d[1]} + {1'b0, d[0]};
    endfunction

endpackage

### rtl/qswd_cell.sv
module qswd_cell
    import qswd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     shift_en,
    input  sym_t     sym_in,
    input  sym_t     code_sym,
    input  sym_t     mask_sym,
    output sym_t     sym_out,
    output err_set_t err_cnt
);

    sym_t sym_reg;
    sym_t sym_next;

    always_comb begin
        sym_next = shift_en ? sym_in : sym_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg <= '0;
        end else begin
            sym_reg <= sym_next;
        end
    end

    // The comparison looks at the symbol this cell takes in on the current shift.
    always_comb begin
        for (int r = 0; r < NUM_ROT; r++) begin
            err_cnt[r] = count_bits((sym_in ^ rot_sym(rot_t'(r), code_sym)) & mask_sym);
        end
    end

    assign sym_out = sym_reg;

endmodule

### rtl/qswd_match.sv
module qswd_match
    import qswd_pkg::*;
(
    input  err_set_t    err_cnt [NUM_CELLS],
    input  logic [5:0]  threshold,
    output match_t      match
);

    localparam int GROUPS    = 4;
    localparam int PER_GROUP = NUM_CELLS / GROUPS;

    logic [3:0]         grp_sum [NUM_ROT][GROUPS];
    logic [5:0]         total   [NUM_ROT];
    logic [NUM_ROT-1:0] hit;

    always_comb begin
        for (int r = 0; r < NUM_ROT; r++) begin
            for (int g = 0; g < GROUPS; g++) begin
                grp_sum[r][g] = '0;
                for (int k = 0; k < PER_GROUP; k++) begin
                    grp_sum[r][g] = grp_sum[r][g] + {2'b00, err_cnt[g*PER_GROUP+k][r]};
                end
            end
            total[r] = '0;
            for (int g = 0; g < GROUPS; g++) begin
                total[r] = total[r] + {2'b00, grp_sum[r][g]};
            end
            hit[r] = (total[r] <= threshold);
        end
    end

    always_comb begin
        match = '0;
        priority if (hit[0]) begin
            match.found = 1'b1;
            match.phase = 2'd0;
        end else if (hit[1]) begin
            match.found = 1'b1;
            match.phase = 2'd1;
        end else if (hit[2]) begin
            match.found = 1'b1;
            match.phase = 2'd2;
        end else if (hit[3]) begin
            match.found = 1'b1;
            match.phase = 2'd3;
        end else begin
            match = '0;
        end
    end

endmodule

### rtl/qpsk_sync_word_detector_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_symbol_in[7:0]
// m_        out        m_valid / m_ready   symbol_out, sync_found, phase_index,
//                                          sync_start[63:0], tagged_length[18:0]
// cfg_      in         cfg_wr_en           cfg_index[1:0], cfg_wdata[31:0]
//
// One transaction is taken per cycle unless stalled; its result is registered.
// The chain of sixteen symbol cells and the four masked error counts settle
// in the cycle of acceptance, so the skip decision is ready for the next symbol.
// A single output register holds the result; input is taken whenever it is
// empty or drained in the same cycle. Synchronous active-low reset clears the
// symbol chain, the counters and the output valid flag, and restores the
// configuration defaults.
module qpsk_sync_word_detector_unit
    import qswd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_symbol_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol_out,
    output logic        m_sync_found,
    output logic [1:0]  m_phase_index,
    output logic [63:0] m_sync_start,
    output logic [18:0] m_tagged_length,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] sync_code_reg;
    logic [31:0] compare_mask_reg;
    logic [5:0]  error_threshold_reg;
    logic [15:0] frame_len_reg;

    logic [4:0]  fill_reg,  fill_next;
    logic [17:0] skip_reg,  skip_next;
    logic [63:0] item_reg,  item_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  symbol_reg;
    logic        found_reg;
    logic [1:0]  phase_reg;
    logic [63:0] start_reg;
    logic [18:0] tag_reg;

    logic        s_accept;
    logic        shift_en;
    logic        full;
    logic        hit;
    match_t      match;

    sym_t        cell_in  [NUM_CELLS];
    sym_t        cell_out [NUM_CELLS];
    err_set_t    err_cnt  [NUM_CELLS];

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign shift_en = s_accept && (skip_reg == '0);
    assign full     = fill_reg[4] || (fill_reg == 5'd15);
    assign hit      = shift_en && full && match.found;

    assign cell_in[0] = s_symbol_in[1:0];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        qswd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .sym_in   (cell_in[k]),
            .code_sym (sync_code_reg[2*k+1:2*k]),
            .mask_sym (compare_mask_reg[2*k+1:2*k]),
            .sym_out  (cell_out[k]),
            .err_cnt  (err_cnt[k])
        );
    end

    qswd_match u_match (
        .err_cnt   (err_cnt),
        .threshold (error_threshold_reg),
        .match     (match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_code_reg       <= '0;
            compare_mask_reg    <= '1;
            error_threshold_reg <= '0;
            frame_len_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_SYNC_CODE:       sync_code_reg       <= cfg_wdata;
                REG_COMPARE_MASK:    compare_mask_reg    <= cfg_wdata;
                REG_ERROR_THRESHOLD: error_threshold_reg <= cfg_wdata[5:0];
                REG_FRAME_LEN:       frame_len_reg       <= cfg_wdata[15:0];
                default:             sync_code_reg       <= sync_code_reg;
            endcase
        end
    end

    always_comb begin
        fill_next = fill_reg;
        skip_next = skip_reg;
        item_next = item_reg;
        if (s_accept) begin
            item_next = item_reg + 64'd1;
            if (skip_reg != '0) begin
                skip_next = skip_reg - 18'd1;
            end else begin
                if (!fill_reg[4]) begin
                    fill_next = fill_reg + 5'd1;
                end
                if (hit) begin
                    skip_next = {frame_len_reg, 2'b00};
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            skip_reg    <= '0;
            item_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            skip_reg    <= skip_next;
            item_reg    <= item_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            symbol_reg <= s_symbol_in;
            found_reg  <= hit;
            phase_reg  <= hit ? match.phase : 2'd0;
            start_reg  <= hit ? (item_reg - START_BACK) : 64'd0;
            tag_reg    <= hit ? ({1'b0, frame_len_reg, 2'b00} + TAG_EXTRA) : 19'd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_symbol_out    = symbol_reg;
    assign m_sync_found    = found_reg;
    assign m_phase_index   = phase_reg;
    assign m_sync_start    = start_reg;
    assign m_tagged_length = tag_reg;

endmodule

### tb/sync_detect_checker.sv
module sync_detect_checker
    import qswd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_symbol_in,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_symbol_out,
    input  logic        m_sync_found,
    input  logic [1:0]  m_phase_index,
    input  logic [63:0] m_sync_start,
    input  logic [18:0] m_tagged_length,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    output int          fail_count,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  symbol;
        logic        found;
        rot_t        phase;
        logic [63:0] start;
        logic [18:0] tag_len;
    } sync_report_t;

    // Symbol map per rotation, packed as {map(3), map(2), map(1), map(0)}.
    localparam logic [7:0] TURN [NUM_ROT] = '{
        {2'd3, 2'd2, 2'd1, 2'd0},
        {2'd2, 2'd0, 2'd3, 2'd1},
        {2'd0, 2'd1, 2'd2, 2'd3},
        {2'd1, 2'd3, 2'd0, 2'd2}
    };

    sync_report_t reports_due [$];

    logic [31:0] code_word;
    logic [31:0] bit_mask;
    logic [5:0]  max_errors;
    logic [15:0] frame_units;

    logic [31:0] history;
    logic [4:0]  held_syms;
    logic [17:0] skip_count;
    logic [63:0] item_pos;

    int mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [31:0] turned_word(input logic [31:0] w, input rot_t rot);
        logic [31:0] t;
        for (int k = 0; k < NUM_CELLS; k++) begin
            t[2*k +: 2] = TURN[rot][int'(w[2*k +: 2]) * 2 +: 2];
        end
        return t;
    endfunction

    task automatic take_symbol(input logic [7:0] b, output sync_report_t rep);
        logic [63:0] here;
        logic [31:0] diff;
        rep = '0;
        rep.symbol = b;
        here = item_pos;
        item_pos = item_pos + 64'd1;
        if (skip_count != 0) begin
            skip_count = skip_count - 18'd1;
        end else begin
            history = {history[29:0], b[1:0]};
            if (held_syms < NUM_CELLS) begin
                held_syms = held_syms + 5'd1;
            end
            if (held_syms == NUM_CELLS) begin
                for (int r = 0; r < NUM_ROT && !rep.found; r++) begin
                    diff = (history ^ turned_word(code_word, rot_t'(r))) & bit_mask;
                    if ($countones(diff) <= max_errors) begin
                        rep.found   = 1'b1;
                        rep.phase   = rot_t'(r);
                        rep.start   = here - START_BACK;
                        rep.tag_len = {1'b0, frame_units, 2'b00} + TAG_EXTRA;
                        skip_count  = {frame_units, 2'b00};
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        sync_report_t seen;
        sync_report_t due;
        logic in_acc;
        logic out_acc;
        in_acc  = s_valid && s_ready;
        out_acc = m_valid && m_ready;
        if (!aresetn) begin
            code_word   = '0;
            bit_mask    = '1;
            max_errors  = '0;
            frame_units = '0;
            history     = '0;
            held_syms   = '0;
            skip_count  = '0;
            item_pos    = '0;
            reports_due.delete();
            results_owed <= 0;
        end else begin
            if (cfg_wr_en) begin
                unique case (reg_index_t'(cfg_index))
                    REG_SYNC_CODE:       code_word   = cfg_wdata;
                    REG_COMPARE_MASK:    bit_mask    = cfg_wdata;
                    REG_ERROR_THRESHOLD: max_errors  = cfg_wdata[5:0];
                    REG_FRAME_LEN:       frame_units = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (out_acc) begin
                seen = '{symbol: m_symbol_out, found: m_sync_found, phase: m_phase_index,
                         start: m_sync_start, tag_len: m_tagged_length};
                if (reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result symbol=%02h found=%0b phase=%0d",
                                 $realtime, seen.symbol, seen.found, seen.phase);
                    end
                end else begin
                    due = reports_due.pop_front();
                    if (seen.symbol !== due.symbol || seen.found !== due.found ||
                        seen.phase !== due.phase || seen.start !== due.start ||
                        seen.tag_len !== due.tag_len) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected sym=%02h found=%0b phase=%0d start=%0d len=%0d",
                                     $realtime, due.symbol, due.found, due.phase,
                                     due.start, due.tag_len);
                            $display("%0t: actual   sym=%02h found=%0b phase=%0d start=%0d len=%0d",
                                     $realtime, seen.symbol, seen.found, seen.phase,
                                     seen.start, seen.tag_len);
                        end
                    end
                end
            end
            if (in_acc) begin
                take_symbol(s_symbol_in, due);
                reports_due.push_back(due);
            end
            results_owed <= results_owed + int'(in_acc) - int'(out_acc);
        end
    end

endmodule

### tb/qpsk_sync_word_detector_unit_test.sv
module qpsk_sync_word_detector_unit_test
    import qswd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int HOLD_CYCLES     = 100;

    localparam logic [7:0] PROBE_BYTES [8] = '{
        8'hFF, 8'h01, 8'h02, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h00
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_symbol_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_symbol_out;
    logic        m_sync_found;
    logic [1:0]  m_phase_index;
    logic [63:0] m_sync_start;
    logic [18:0] m_tagged_length;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int fail_count;
    int results_owed;
    int stall_cycles = 0;
    int phase_items;
    bit tx_gaps   = 1'b0;
    bit rx_gaps   = 1'b0;
    bit long_hold = 1'b0;

    always #10 aclk = ~aclk;

    qpsk_sync_word_detector_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol_in     (s_symbol_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_symbol_out    (m_symbol_out),
        .m_sync_found    (m_sync_found),
        .m_phase_index   (m_phase_index),
        .m_sync_start    (m_sync_start),
        .m_tagged_length (m_tagged_length),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    sync_detect_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol_in     (s_symbol_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_symbol_out    (m_symbol_out),
        .m_sync_found    (m_sync_found),
        .m_phase_index   (m_phase_index),
        .m_sync_start    (m_sync_start),
        .m_tagged_length (m_tagged_length),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_symbol(input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_symbol_in <= b;
        do @(posedge aclk); while (!s_ready);
        phase_items++;
    endtask

    // A rotated copy of the sync word with a few bit errors, sometimes cut short,
    // followed by a payload that exactly covers the skip after a match.
    task automatic send_frame(input logic [31:0] code, input logic [15:0] flen);
        logic [31:0] word;
        rot_t        rot;
        int          n_syms;
        rot = rot_t'($urandom_range(0, 3));
        for (int k = 0; k < NUM_CELLS; k++) begin
            word[2*k +: 2] = rot_sym(rot, code[2*k +: 2]);
        end
        repeat ($urandom_range(0, 3)) word[$urandom_range(0, 31)] ^= 1'b1;
        n_syms = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 15) : NUM_CELLS;
        for (int k = NUM_CELLS - 1; k >= NUM_CELLS - n_syms; k--) begin
            send_symbol({6'($urandom), word[2*k +: 2]});
        end
        if (n_syms == NUM_CELLS) begin
            repeat (int'(flen) * 4) send_symbol(8'($urandom));
        end
    endtask

    task automatic load_settings(input logic [31:0] code, input logic [31:0] mask,
                                 input logic [5:0] thr, input logic [15:0] flen);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SYNC_CODE;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_index <= REG_COMPARE_MASK;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_index <= REG_ERROR_THRESHOLD;
        cfg_wdata <= {26'd0, thr};
        @(posedge aclk);
        cfg_index <= REG_FRAME_LEN;
        cfg_wdata <= {16'd0, flen};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] code;
        logic [31:0] mask;
        logic [5:0]  thr;
        logic [15:0] flen;
        bit          hold_done;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_symbol_in = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_SYNC_CODE;
        cfg_wdata   = '0;
        hold_done   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_CELLS; i++) begin
            send_symbol((i % 2 == 0) ? 8'h00 : 8'hFC);
        end
        foreach (PROBE_BYTES[i]) begin
            send_symbol(PROBE_BYTES[i]);
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            unique case (p)
                0: begin
                    code = 32'hFFFF_FFFF; mask = 32'hFFFF_FFFF; thr = 6'd0; flen = 16'd0;
                end
                1: begin
                    code = 32'h0; mask = 32'h0; thr = 6'd32; flen = 16'd1;
                end
                2: begin
                    code = $urandom; mask = 32'hFFFF_FFFF; thr = 6'd40; flen = 16'd2;
                end
                default: begin
                    code = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
                    mask = ($urandom_range(0, 2) == 0) ? $urandom : 32'hFFFF_FFFF;
                    thr  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(4, 32))
                                                        : 6'($urandom_range(0, 3));
                    flen = 16'($urandom_range(0, 6));
                end
            endcase
            load_settings(code, mask, thr, flen);
            tx_gaps = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            rx_gaps = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                if (p == 3 && phase_items >= 40 && !hold_done) begin
                    long_hold = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 12)) send_symbol(8'($urandom));
                end else begin
                    send_frame(code, flen);
                end
            end
            wait_drained();
        end

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        load_settings($urandom, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        repeat (40) send_symbol(8'($urandom));
        wait_drained();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
